// ===== hdl/nfa_pkg.sv =====
package nfa_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEAP_PAGES   = 16;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;

  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int DEPTH       = (HEAP_PAGES * PAGE_BYTES) / ALIGN_BYTES;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int HDR_UNITS   = HEADER_BYTES / ALIGN_BYTES;
  localparam int PAGE_UNITS  = PAGE_BYTES / ALIGN_BYTES;

  localparam int FUNC_W  = 2;
  localparam int BYTES_W = 16;
  localparam int STAT_W  = 3;
  localparam int PAGES_W = 5;

  localparam logic [PAGES_W-1:0] REGION_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_AGAIN    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTREADY = 3'd4;

  // Block header as stored; size and prev are in alignment units.
  typedef struct packed {
    logic             mark;
    logic             used;
    logic             has_prev;
    logic             has_next;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] size;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_INIT,
    OP_A_START,
    OP_A_SPLIT,
    OP_A_EXACT,
    OP_A_STEP,
    OP_A_HEAD,
    OP_LINK,
    OP_F_START,
    OP_F_HEAD,
    OP_F_NMERGE,
    OP_F_PREAD,
    OP_F_PMERGE,
    OP_F_WH
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic              finish;
    logic [STAT_W-1:0] status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              clear_done;
    logic              heap_ready;
    logic [FUNC_W-1:0] func;
    logic              bad_fmt;
    logic              split;
    logic              exact;
    logic              search_end;
    logic              rd_used;
    logic              rd_live;
    logic              rd_hn;
    logic              h_hn;
    logic              h_hp;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_A_EVAL,
    S_A_AFT,
    S_A_HEAD,
    S_F_H,
    S_F_N,
    S_F_NA,
    S_F_PC,
    S_F_P,
    S_F_PA,
    S_F_WH,
    S_RESP
  } state_e;

endpackage

// ===== hdl/nfa_req_if.sv =====
interface nfa_req_if;
  import nfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [BYTES_W-1:0] request_bytes;
  logic [BYTES_W-1:0] payload_address;
  modport source (output valid, func, request_bytes, payload_address, input ready);
  modport sink (input valid, func, request_bytes, payload_address, output ready);
endinterface

// ===== hdl/nfa_rsp_if.sv =====
interface nfa_rsp_if;
  import nfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [BYTES_W-1:0] address;
  modport source (output valid, status, address, input ready);
  modport sink (input valid, status, address, output ready);
endinterface

// ===== hdl/nfa_cfg_if.sv =====
interface nfa_cfg_if;
  import nfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [PAGES_W-1:0] region_pages;
  modport source (output valid, region_pages, input ready);
  modport sink (input valid, region_pages, output ready);
endinterface

// ===== hdl/nfa_ram.sv =====
module nfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/nfa_dp.sv =====
module nfa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nfa_pkg::ctrl_cmd_t          cmd_i,
  output nfa_pkg::dp_stat_t           stat_o,
  input  logic [nfa_pkg::FUNC_W-1:0]  func_i,
  input  logic [nfa_pkg::BYTES_W-1:0] request_bytes_i,
  input  logic [nfa_pkg::BYTES_W-1:0] payload_address_i,
  input  logic [nfa_pkg::PAGES_W-1:0] region_pages_i,
  output logic [nfa_pkg::STAT_W-1:0]  status_o,
  output logic [nfa_pkg::BYTES_W-1:0] address_o
);
  import nfa_pkg::*;

  localparam int SW = IDX_W + 2;
  localparam logic [SW-1:0] HDR_U   = SW'(HDR_UNITS);
  localparam logic [SW-1:0] DEPTH_U = SW'(DEPTH);

  hdr_t rd;
  hdr_t wdata, h_q, h_d;
  logic [HDR_W-1:0] rdata;
  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  logic rd_load;

  logic [IDX_W-1:0] cur_q, stop_q, steps_q, idx_q, link_q, ss_q, clr_q;
  logic [IDX_W-1:0] ss_d, link_d;
  logic ready_q;
  logic [FUNC_W-1:0] func_q;
  logic [IDX_W:0] need_q, need_d;
  logic [BYTES_W-1:0] pay_q, res_addr_q, res_addr_d;
  logic [STAT_W-1:0] status_q;

  logic [SW-1:0] succ_raw, hsucc_raw, need_hdr, ni_raw;
  logic [IDX_W-1:0] succ_idx, next_idx, hsucc_idx, pay_idx;
  logic [BYTES_W:0] req_sum, pay_start;
  logic [PAGES_W-1:0] pages;
  logic [IDX_W-1:0] init_size;
  logic split, exact, bad_fmt;

  function automatic logic [BYTES_W-1:0] pay_of(logic [IDX_W-1:0] idx);
    logic [BYTES_W:0] t;
    t = ((BYTES_W+1)'(idx) << ALIGN_SHIFT) + (BYTES_W+1)'(HEADER_BYTES);
    return t[BYTES_W-1:0];
  endfunction

  nfa_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd = hdr_t'(rdata);

  always_comb begin
    succ_raw  = {2'b00, cur_q} + HDR_U + {2'b00, rd.size};
    succ_idx  = (succ_raw < DEPTH_U) ? succ_raw[IDX_W-1:0] : '0;
    next_idx  = rd.has_next ? succ_idx : '0;
    hsucc_raw = {2'b00, idx_q} + HDR_U + {2'b00, h_q.size};
    hsucc_idx = (hsucc_raw < DEPTH_U) ? hsucc_raw[IDX_W-1:0] : '0;
    need_hdr  = {1'b0, need_q} + HDR_U;
    ni_raw    = {2'b00, cur_q} + need_hdr;
    split     = !rd.used && (need_hdr < {2'b00, rd.size}) && (ni_raw < DEPTH_U);
    exact     = !rd.used && !(need_hdr < {2'b00, rd.size}) && (need_q <= {1'b0, rd.size});
    req_sum   = {1'b0, request_bytes_i} + (BYTES_W+1)'(ALIGN_BYTES - 1);
    need_d    = (IDX_W+1)'(req_sum >> ALIGN_SHIFT);
    pay_start = {1'b0, pay_q} - (BYTES_W+1)'(HEADER_BYTES);
    pay_idx   = IDX_W'(pay_start >> ALIGN_SHIFT);
    bad_fmt   = (pay_q == '0) || (pay_q < BYTES_W'(HEADER_BYTES))
                || (pay_start[ALIGN_SHIFT-1:0] != '0);
    if (region_pages_i == '0) begin
      pages = PAGES_W'(1);
    end else if (region_pages_i > PAGES_W'(HEAP_PAGES)) begin
      pages = PAGES_W'(HEAP_PAGES);
    end else begin
      pages = region_pages_i;
    end
    init_size = IDX_W'(int'(pages) * PAGE_UNITS - HDR_UNITS);
  end

  // Memory ports
  always_comb begin
    we      = 1'b1;
    waddr   = cur_q;
    wdata   = rd;
    raddr   = cur_q;
    rd_load = 1'b0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        waddr = clr_q;
        wdata = '0;
      end
      OP_INIT: begin
        waddr = '0;
        wdata = '{mark: 1'b1, used: 1'b0, has_prev: 1'b0, has_next: 1'b0,
                  prev: '0, size: init_size};
      end
      OP_A_START: begin
        we = 1'b0;
        raddr = ss_q;
        rd_load = 1'b1;
      end
      OP_F_START: begin
        we = 1'b0;
        raddr = pay_idx;
        rd_load = 1'b1;
      end
      OP_A_SPLIT: begin
        waddr = ni_raw[IDX_W-1:0];
        wdata = '{mark: 1'b1, used: 1'b0, has_prev: 1'b1, has_next: rd.has_next,
                  prev: cur_q, size: IDX_W'({2'b00, rd.size} - need_hdr)};
        raddr = next_idx;
        rd_load = 1'b1;
      end
      OP_A_STEP, OP_F_HEAD: begin
        we = 1'b0;
        raddr = next_idx;
        rd_load = 1'b1;
      end
      OP_A_EXACT: wdata.used = 1'b1;
      OP_LINK:    wdata.prev = link_q;
      OP_A_HEAD: begin
        waddr = idx_q;
        wdata = h_q;
        wdata.size = need_q[IDX_W-1:0];
        wdata.used = 1'b1;
        wdata.has_next = 1'b1;
      end
      OP_F_NMERGE: begin
        wdata.mark = 1'b0;
        raddr = next_idx;
        rd_load = 1'b1;
      end
      OP_F_PREAD: begin
        we = 1'b0;
        raddr = h_q.prev;
        rd_load = 1'b1;
      end
      OP_F_PMERGE: begin
        wdata.size = IDX_W'({2'b00, rd.size} + {2'b00, h_q.size} + HDR_U);
        wdata.has_next = h_q.has_next;
        raddr = hsucc_idx;
        rd_load = 1'b1;
      end
      OP_F_WH: begin
        waddr = idx_q;
        wdata = h_q;
      end
      default: we = 1'b0;
    endcase
  end

  // Register updates
  always_comb begin
    h_d        = h_q;
    ss_d       = ss_q;
    link_d     = link_q;
    res_addr_d = res_addr_q;
    case (cmd_i.op)
      OP_LATCH:  res_addr_d = '0;
      OP_INIT:   ss_d = '0;
      OP_A_SPLIT: begin
        h_d    = rd;
        link_d = ni_raw[IDX_W-1:0];
      end
      OP_A_EXACT: begin
        ss_d       = next_idx;
        res_addr_d = pay_of(cur_q);
      end
      OP_A_HEAD: begin
        ss_d       = link_q;
        res_addr_d = pay_of(idx_q);
      end
      OP_F_HEAD: begin
        h_d      = rd;
        h_d.used = 1'b0;
      end
      OP_F_NMERGE: begin
        h_d.size     = IDX_W'({2'b00, h_q.size} + {2'b00, rd.size} + HDR_U);
        h_d.has_next = rd.has_next;
        link_d       = idx_q;
        if (ss_q == cur_q) begin
          ss_d = idx_q;
        end
      end
      OP_F_PMERGE: begin
        h_d.mark = 1'b0;
        link_d   = cur_q;
        if (ss_q == idx_q) begin
          ss_d = cur_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q    <= '0;
      ready_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      ss_q <= ss_d;
      if (cmd_i.op == OP_INIT) begin
        ready_q <= 1'b1;
      end
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q        <= h_d;
    link_q     <= link_d;
    res_addr_q <= res_addr_d;
    if (rd_load) begin
      cur_q <= raddr;
    end
    if (cmd_i.op == OP_LATCH) begin
      func_q <= func_i;
      need_q <= need_d;
      pay_q  <= payload_address_i;
    end
    if (cmd_i.op == OP_A_START) begin
      stop_q  <= ss_q;
      steps_q <= '0;
    end
    if (cmd_i.op == OP_A_STEP) begin
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.op == OP_A_SPLIT) begin
      idx_q <= cur_q;
    end
    if (cmd_i.op == OP_F_START) begin
      idx_q <= pay_idx;
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
    end
  end

  assign stat_o = '{
    clear_done: (clr_q == IDX_W'(DEPTH - 1)),
    heap_ready: ready_q,
    func:       func_q,
    bad_fmt:    bad_fmt,
    split:      split,
    exact:      exact,
    search_end: (next_idx == stop_q) || (steps_q == IDX_W'(DEPTH - 1)),
    rd_used:    rd.used,
    rd_live:    rd.mark && rd.used,
    rd_hn:      rd.has_next,
    h_hn:       h_q.has_next,
    h_hp:       h_q.has_prev
  };

  assign status_o  = status_q;
  assign address_o = res_addr_q;

  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |=> ready_q)
    else $error("heap ready flag dropped");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && cmd_i.status != ST_OK) |=> res_addr_q == '0)
    else $error("failed operation reports an address");

  a_split_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_A_SPLIT) |-> (ni_raw < DEPTH_U) && !rd.used)
    else $error("split outside region or of used block");

endmodule

// ===== hdl/nfa_ctrl.sv =====
module nfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nfa_pkg::dp_stat_t  stat_i,
  output nfa_pkg::ctrl_cmd_t cmd_o,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import nfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clear_done) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        state_d = S_RESP;
        if (stat_i.heap_ready) begin
          if (stat_i.func == FUNC_ALLOC) begin
            state_d = S_A_EVAL;
          end else if (stat_i.func == FUNC_FREE && !stat_i.bad_fmt) begin
            state_d = S_F_H;
          end
        end
      end
      S_A_EVAL: begin
        if (stat_i.split) begin
          state_d = stat_i.rd_hn ? S_A_AFT : S_A_HEAD;
        end else if (stat_i.exact || stat_i.search_end) begin
          state_d = S_RESP;
        end
      end
      S_A_AFT:  state_d = S_A_HEAD;
      S_A_HEAD: state_d = S_RESP;
      S_F_H: begin
        if (!stat_i.rd_live) begin
          state_d = S_RESP;
        end else begin
          state_d = stat_i.rd_hn ? S_F_N : S_F_PC;
        end
      end
      S_F_N: state_d = (!stat_i.rd_used && stat_i.rd_hn) ? S_F_NA : S_F_PC;
      S_F_NA: state_d = S_F_PC;
      S_F_PC: state_d = stat_i.h_hp ? S_F_P : S_F_WH;
      S_F_P:  state_d = (!stat_i.rd_used && stat_i.h_hn) ? S_F_PA : S_F_WH;
      S_F_PA: state_d = S_F_WH;
      S_F_WH: state_d = S_RESP;
      S_RESP: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '{op: OP_NONE, finish: 1'b0, status: ST_OK};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LATCH;
      end
      S_DISP: begin
        cmd_o.finish = 1'b1;
        unique case (stat_i.func)
          FUNC_INIT: begin
            if (stat_i.heap_ready) begin
              cmd_o.status = ST_AGAIN;
            end else begin
              cmd_o.op = OP_INIT;
            end
          end
          FUNC_ALLOC: begin
            if (!stat_i.heap_ready) begin
              cmd_o.status = ST_NOTREADY;
            end else begin
              cmd_o.op = OP_A_START;
              cmd_o.finish = 1'b0;
            end
          end
          FUNC_FREE: begin
            if (!stat_i.heap_ready) begin
              cmd_o.status = ST_NOTREADY;
            end else if (stat_i.bad_fmt) begin
              cmd_o.status = ST_BADFREE;
            end else begin
              cmd_o.op = OP_F_START;
              cmd_o.finish = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_A_EVAL: begin
        if (stat_i.split) begin
          cmd_o.op = OP_A_SPLIT;
        end else if (stat_i.exact) begin
          cmd_o.op = OP_A_EXACT;
          cmd_o.finish = 1'b1;
        end else if (stat_i.search_end) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NOFIT;
        end else begin
          cmd_o.op = OP_A_STEP;
        end
      end
      S_A_AFT, S_F_NA, S_F_PA: cmd_o.op = OP_LINK;
      S_A_HEAD: begin
        cmd_o.op = OP_A_HEAD;
        cmd_o.finish = 1'b1;
      end
      S_F_H: begin
        if (!stat_i.rd_live) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_BADFREE;
        end else begin
          cmd_o.op = OP_F_HEAD;
        end
      end
      S_F_N:  if (!stat_i.rd_used) cmd_o.op = OP_F_NMERGE;
      S_F_PC: if (stat_i.h_hp) cmd_o.op = OP_F_PREAD;
      S_F_P:  if (!stat_i.rd_used) cmd_o.op = OP_F_PMERGE;
      S_F_WH: begin
        cmd_o.op = OP_F_WH;
        cmd_o.finish = 1'b1;
      end
      S_RESP: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o && cmd_o.op != OP_CLEAR)
    else $error("input taken while busy");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_finish_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_RESP)
    else $error("finished operation did not present result");

endmodule

// ===== hdl/next_fit_heap_allocator.sv =====
// channel  | dir | payload                                  | beat when
// req_i    | in  | func, request_bytes, payload_address     | valid && ready
// rsp_o    | out | status, address                          | valid && ready
// cfg_i    | in  | region_pages                             | valid && ready
//
// After reset the header memory is swept clear; no request beat is taken
// during the sweep. Initialize and rejected requests are finished in the
// dispatch step and then give the response beat. Allocate walks the block
// headers and takes extra steps for a split. Free works through the header
// memory's read-modify-write steps.
// One request is in flight at a time; a stalled result holds in its register.
module next_fit_heap_allocator (
  input logic     clk_i,
  input logic     rst_ni,
  nfa_req_if.sink   req_i,
  nfa_rsp_if.source rsp_o,
  nfa_cfg_if.sink   cfg_i
);
  import nfa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic [PAGES_W-1:0] region_pages_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_pages_q <= REGION_RESET;
    end else if (cfg_i.valid) begin
      region_pages_q <= cfg_i.region_pages;
    end
  end

  nfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready)
  );

  nfa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .func_i            (req_i.func),
    .request_bytes_i   (req_i.request_bytes),
    .payload_address_i (req_i.payload_address),
    .region_pages_i    (region_pages_q),
    .status_o          (rsp_o.status),
    .address_o         (rsp_o.address)
  );

endmodule
